[src/heightmap_triangle_sample_top_macros.svh]
// Assertion macros shared by the heightmap sampler RTL.
// The macros expect clk and rst_n to be visible where they are used.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLE_TOP_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hts_pkg.sv]
// Package for the heightmap triangle sampler: widths, register indexes,
// command codes, sequencer states and the control bundle. No dependencies.
`default_nettype none

package hts_pkg;

    localparam int MAX_SIDE_DEF = 64;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int SIDE_CFG_W = 7;
    localparam int FRAC_W     = 16;
    localparam int HGT_W      = 8;
    localparam int SIDX_W     = 12;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int COEF_W     = 10;
    localparam int ACC_W      = 28;
    localparam int SCALE_W    = 58;
    localparam int TQ_W       = 42;
    localparam int SER_W      = 43;
    localparam int QUO_W      = 34;
    localparam int SUM_W      = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE    = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [DATA_W-1:0]     INV_SPACING_RST  = 32'h0001_0000;
    localparam logic [DATA_W-1:0]     HEIGHT_SCALE_RST = 32'h0001_0000;
    localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RST    = 7'd64;

    // 0.001 in Q16.16, kept off the far grid edge when clamping.
    localparam int CLAMP_MARGIN = 66;
    // Half of 255 * 2^16, for round-half-up on the divide by 255 * 2^16.
    localparam int ROUND_BIAS   = 255 * 32768;
    localparam int DIV_CONST    = 255;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Z,
        ST_GRID_Z,
        ST_CHECK,
        ST_MUL_ROW,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_SEL,
        ST_MUL_A,
        ST_MUL_B,
        ST_ACC,
        ST_SCALE,
        ST_DIV0,
        ST_DIV1,
        ST_DIV2,
        ST_FIN
    } hts_state_t;

    typedef struct packed {
        hts_state_t state;
        logic       ready;
        logic       accept;
        logic       out_load;
    } hts_ctl_t;

endpackage

`default_nettype wire

[src/hts_mul.sv]
// Shared signed multiplier of the sampler with a registered product.
// Depends on hts_pkg for the operand width.
`default_nettype none

module hts_mul (
    input  wire logic                                  clk,
    input  wire logic signed [hts_pkg::MUL_W-1:0]      op_a,
    input  wire logic signed [hts_pkg::MUL_W-1:0]      op_b,
    output logic signed      [hts_pkg::PROD_W-1:0]     prod
);

    logic signed [hts_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[src/hts_store.sv]
// Height sample memory with one write and one registered read port, plus
// the clearing pass that zeroes it after reset. Depends on hts_pkg.
`default_nettype none

module hts_store #(
    parameter int DEPTH  = hts_pkg::MAX_SIDE_DEF * hts_pkg::MAX_SIDE_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [hts_pkg::HGT_W-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [hts_pkg::HGT_W-1:0]  rd_data,
    output logic                            clear_busy
);

    logic [hts_pkg::HGT_W-1:0] mem [DEPTH];
    logic [hts_pkg::HGT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]         clear_cnt_reg;
    logic                      clear_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg  <= '0;
            clear_busy_reg <= 1'b1;
        end
        else if (clear_busy_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            mem[clear_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

endmodule

`default_nettype wire

[src/hts_ctrl.sv]
// Sequencer of the sampler: steps one request through the shared
// multiplier and memory port. Depends on hts_pkg for states and hts_ctl_t.
`default_nettype none

module hts_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              cmd,
    input  wire logic              clear_busy,
    input  wire logic              miss,
    input  wire logic              out_free,
    output hts_pkg::hts_ctl_t      ctl
);

    hts_pkg::hts_state_t state_reg;
    hts_pkg::hts_state_t state_next;
    logic                accept;

    assign accept = (state_reg == hts_pkg::ST_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hts_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hts_pkg::ST_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = hts_pkg::ST_IDLE;
                end
            end
            hts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == hts_pkg::CMD_QUERY) ? hts_pkg::ST_MUL_X
                                                              : hts_pkg::ST_FIN;
                end
            end
            hts_pkg::ST_MUL_X:   state_next = hts_pkg::ST_MUL_Z;
            hts_pkg::ST_MUL_Z:   state_next = hts_pkg::ST_GRID_Z;
            hts_pkg::ST_GRID_Z:  state_next = hts_pkg::ST_CHECK;
            hts_pkg::ST_CHECK:   state_next = miss ? hts_pkg::ST_FIN : hts_pkg::ST_MUL_ROW;
            hts_pkg::ST_MUL_ROW: state_next = hts_pkg::ST_RD0;
            hts_pkg::ST_RD0:     state_next = hts_pkg::ST_RD1;
            hts_pkg::ST_RD1:     state_next = hts_pkg::ST_RD2;
            hts_pkg::ST_RD2:     state_next = hts_pkg::ST_RD3;
            hts_pkg::ST_RD3:     state_next = hts_pkg::ST_SEL;
            hts_pkg::ST_SEL:     state_next = hts_pkg::ST_MUL_A;
            hts_pkg::ST_MUL_A:   state_next = hts_pkg::ST_MUL_B;
            hts_pkg::ST_MUL_B:   state_next = hts_pkg::ST_ACC;
            hts_pkg::ST_ACC:     state_next = hts_pkg::ST_SCALE;
            hts_pkg::ST_SCALE:   state_next = hts_pkg::ST_DIV0;
            hts_pkg::ST_DIV0:    state_next = hts_pkg::ST_DIV1;
            hts_pkg::ST_DIV1:    state_next = hts_pkg::ST_DIV2;
            hts_pkg::ST_DIV2:    state_next = hts_pkg::ST_FIN;
            hts_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = hts_pkg::ST_IDLE;
                end
            end
            default:             state_next = hts_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.state    = state_reg;
        ctl.ready    = (state_reg == hts_pkg::ST_IDLE);
        ctl.accept   = accept;
        ctl.out_load = (state_reg == hts_pkg::ST_FIN) && out_free;
    end

endmodule

`default_nettype wire

[src/heightmap_triangle_sample_top.sv]
// Top level of the heightmap triangle sampler: configuration registers and
// the query datapath. Depends on hts_pkg, hts_mul, hts_store, hts_ctrl.
//
// Channel  Dir   Handshake             Payload
// cfg      in    cfg_we                cfg_index, cfg_data
// in       in    in_valid / in_ready   cmd, query_x, query_z, clamp_enable,
//                                      sample_index, sample_value
// out      out   out_valid / out_ready hit, height_out
//
// A query uses the one 33x33 multiplier six times and the single memory read port
// four times. A query that misses ends after the clamp or miss check; a sample
// write goes straight to the final step.
// After reset the sample memory is zeroed one entry per cycle, all MAX_SIDE*MAX_SIDE
// entries (4096 by default), with in_ready low; configuration writes still land.
// A result that is not taken holds in the output register; the sequencer waits
// in its final step until the register frees up.
`default_nettype none

`include "heightmap_triangle_sample_top_macros.svh"

module heightmap_triangle_sample_top #(
    parameter int MAX_SIDE = hts_pkg::MAX_SIDE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [hts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hts_pkg::DATA_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic signed [hts_pkg::DATA_W-1:0]  query_x,
    input  wire logic signed [hts_pkg::DATA_W-1:0]  query_z,
    input  wire logic                               clamp_enable,
    input  wire logic [hts_pkg::SIDX_W-1:0]         sample_index,
    input  wire logic [hts_pkg::HGT_W-1:0]          sample_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    hit,
    output logic signed [hts_pkg::DATA_W-1:0]       height_out
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FW     = hts_pkg::FRAC_W;
    localparam int LX_W   = SIDE_W + FW + 1;
    localparam int WIDE_W = hts_pkg::SIDX_W + ADDR_W;

    // Configuration registers.
    logic [hts_pkg::DATA_W-1:0]     origin_x_reg;
    logic [hts_pkg::DATA_W-1:0]     origin_y_reg;
    logic [hts_pkg::DATA_W-1:0]     origin_z_reg;
    logic [hts_pkg::DATA_W-1:0]     inv_spacing_reg;
    logic [hts_pkg::DATA_W-1:0]     height_scale_reg;
    logic [hts_pkg::SIDE_CFG_W-1:0] grid_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            origin_z_reg     <= '0;
            inv_spacing_reg  <= hts_pkg::INV_SPACING_RST;
            height_scale_reg <= hts_pkg::HEIGHT_SCALE_RST;
            grid_side_reg    <= hts_pkg::GRID_SIDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hts_pkg::CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                hts_pkg::CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                hts_pkg::CFG_ORIGIN_Z:     origin_z_reg     <= cfg_data;
                hts_pkg::CFG_INV_SPACING:  inv_spacing_reg  <= cfg_data;
                hts_pkg::CFG_HEIGHT_SCALE: height_scale_reg <= cfg_data;
                hts_pkg::CFG_GRID_SIDE:    grid_side_reg    <= cfg_data[hts_pkg::SIDE_CFG_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Side in use, limited to the range the memory supports.
    logic [SIDE_W-1:0] side;

    always_comb
    begin
        if (grid_side_reg < 7'd2)
        begin
            side = SIDE_W'(2);
        end
        else if (32'(grid_side_reg) > MAX_SIDE)
        begin
            side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side = SIDE_W'(grid_side_reg);
        end
    end

    hts_pkg::hts_ctl_t ctl;
    logic              clear_busy;
    logic              miss;
    logic              out_free;

    // Datapath registers.
    logic [hts_pkg::DATA_W-1:0]         mag_x_reg;
    logic [hts_pkg::DATA_W-1:0]         mag_z_reg;
    logic                               dneg_x_reg;
    logic                               dneg_z_reg;
    logic                               clamp_reg;
    logic [LX_W-1:0]                    lx_reg;
    logic [LX_W-1:0]                    lz_reg;
    logic                               nx_reg;
    logic                               nz_reg;
    logic [IDX_W-1:0]                   vx_reg;
    logic [IDX_W-1:0]                   vz_reg;
    logic [FW-1:0]                      bx_reg;
    logic [FW-1:0]                      bz_reg;
    logic [ADDR_W-1:0]                  base_reg;
    logic [hts_pkg::HGT_W-1:0]          h00_reg;
    logic [hts_pkg::HGT_W-1:0]          h10_reg;
    logic [hts_pkg::HGT_W-1:0]          h01_reg;
    logic signed [hts_pkg::COEF_W-1:0]  coef_a_reg;
    logic signed [hts_pkg::COEF_W-1:0]  coef_b_reg;
    logic signed [hts_pkg::ACC_W-1:0]   acc_reg;
    logic [hts_pkg::TQ_W-1:0]           t_reg;
    logic [hts_pkg::QUO_W-1:0]          qest_reg;
    logic [hts_pkg::QUO_W-1:0]          q_reg;
    logic                               hit_flag_reg;

    logic                               out_valid_reg;
    logic                               hit_reg;
    logic [hts_pkg::DATA_W-1:0]         height_reg;

    // Offset of the query point from the grid center, as sign and magnitude.
    logic signed [hts_pkg::DATA_W:0] diff_x;
    logic signed [hts_pkg::DATA_W:0] diff_z;
    logic signed [hts_pkg::DATA_W:0] ndiff_x;
    logic signed [hts_pkg::DATA_W:0] ndiff_z;

    assign diff_x  = {query_x[hts_pkg::DATA_W-1], query_x}
                   - {origin_x_reg[hts_pkg::DATA_W-1], origin_x_reg};
    assign diff_z  = {query_z[hts_pkg::DATA_W-1], query_z}
                   - {origin_z_reg[hts_pkg::DATA_W-1], origin_z_reg};
    assign ndiff_x = -diff_x;
    assign ndiff_z = -diff_z;

    // Shared multiplier and its operand selection.
    logic signed [hts_pkg::MUL_W-1:0]  op_a;
    logic signed [hts_pkg::MUL_W-1:0]  op_b;
    logic signed [hts_pkg::PROD_W-1:0] prod;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ctl.state)
            hts_pkg::ST_MUL_X:
            begin
                op_a = {1'b0, mag_x_reg};
                op_b = {1'b0, inv_spacing_reg};
            end
            hts_pkg::ST_MUL_Z:
            begin
                op_a = {1'b0, mag_z_reg};
                op_b = {1'b0, inv_spacing_reg};
            end
            hts_pkg::ST_MUL_ROW:
            begin
                op_a = hts_pkg::MUL_W'(vz_reg);
                op_b = hts_pkg::MUL_W'(side);
            end
            hts_pkg::ST_MUL_A:
            begin
                op_a = hts_pkg::MUL_W'(bx_reg);
                op_b = {{(hts_pkg::MUL_W - hts_pkg::COEF_W){coef_a_reg[hts_pkg::COEF_W-1]}},
                        coef_a_reg};
            end
            hts_pkg::ST_MUL_B:
            begin
                op_a = hts_pkg::MUL_W'(bz_reg);
                op_b = {{(hts_pkg::MUL_W - hts_pkg::COEF_W){coef_b_reg[hts_pkg::COEF_W-1]}},
                        coef_b_reg};
            end
            hts_pkg::ST_SCALE:
            begin
                op_a = acc_reg[hts_pkg::ACC_W-1] ? '0 : hts_pkg::MUL_W'(unsigned'(acc_reg));
                op_b = {1'b0, height_scale_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    hts_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Grid conversion of whichever axis product sits in the multiplier output.
    // The offset is (side-1)/2 in Q32.32; a positive magnitude is capped at side.
    logic [63:0]     g_m;
    logic [63:0]     g_offset;
    logic [63:0]     g_cap;
    logic [63:0]     g_loc;
    logic            g_neg_in;
    logic            g_below;
    logic [LX_W-1:0] g_lx;

    always_comb
    begin
        g_m      = prod[63:0];
        g_offset = (64'(side) - 64'd1) << 31;
        g_cap    = 64'(side) << 32;
        g_neg_in = (ctl.state == hts_pkg::ST_MUL_Z) ? dneg_x_reg : dneg_z_reg;
        g_below  = 1'b0;
        if (g_neg_in)
        begin
            g_below = (g_m > g_offset);
            g_loc   = g_offset - g_m;
        end
        else
        begin
            g_loc = g_offset + ((g_m > g_cap) ? g_cap : g_m);
        end
        g_lx = g_below ? '0 : g_loc[LX_W+FW-1:FW];
    end

    // Clamp or miss test on both coordinates.
    logic [LX_W-1:0] top_lim;
    logic [LX_W-1:0] hi_lim;
    logic [LX_W-1:0] sel_x;
    logic [LX_W-1:0] sel_z;

    always_comb
    begin
        top_lim = LX_W'(side - 1'b1) << FW;
        hi_lim  = top_lim - LX_W'(hts_pkg::CLAMP_MARGIN);
        if (clamp_reg)
        begin
            sel_x = (lx_reg > hi_lim) ? hi_lim : lx_reg;
            sel_z = (lz_reg > hi_lim) ? hi_lim : lz_reg;
        end
        else
        begin
            sel_x = lx_reg;
            sel_z = lz_reg;
        end
        miss = !clamp_reg && (nx_reg || nz_reg || (lx_reg >= top_lim) || (lz_reg >= top_lim));
    end

    // Memory addressing: the four corners of the cell.
    logic [ADDR_W-1:0]         base_now;
    logic [ADDR_W-1:0]         rd_addr;
    logic [hts_pkg::HGT_W-1:0] rd_data;
    logic [WIDE_W-1:0]         idx_wide;
    logic                      wr_en;

    assign base_now = prod[ADDR_W-1:0] + ADDR_W'(vx_reg);
    assign idx_wide = {{ADDR_W{1'b0}}, sample_index};
    assign wr_en    = ctl.accept && (cmd == hts_pkg::CMD_WRITE)
                   && (idx_wide < WIDE_W'(DEPTH));

    always_comb
    begin
        case (ctl.state)
            hts_pkg::ST_RD0: rd_addr = base_now;
            hts_pkg::ST_RD1: rd_addr = base_reg + 1'b1;
            hts_pkg::ST_RD2: rd_addr = base_reg + ADDR_W'(side);
            hts_pkg::ST_RD3: rd_addr = base_reg + ADDR_W'(side) + 1'b1;
            default:         rd_addr = base_reg;
        endcase
    end

    hts_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (idx_wide[ADDR_W-1:0]),
        .wr_data    (sample_value),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .clear_busy (clear_busy)
    );

    // Triangle choice. Even rows split along (0,0)-(1,1), odd rows along
    // (1,0)-(0,1); the far triangle on odd rows has its own constant term.
    logic signed [hts_pkg::COEF_W-1:0] e00;
    logic signed [hts_pkg::COEF_W-1:0] e10;
    logic signed [hts_pkg::COEF_W-1:0] e01;
    logic signed [hts_pkg::COEF_W-1:0] e11;
    logic signed [hts_pkg::COEF_W-1:0] sel_a;
    logic signed [hts_pkg::COEF_W-1:0] sel_b;
    logic signed [hts_pkg::COEF_W-1:0] sel_c;
    logic [FW:0]                       one_minus_bz;

    always_comb
    begin
        e00          = hts_pkg::COEF_W'(h00_reg);
        e10          = hts_pkg::COEF_W'(h10_reg);
        e01          = hts_pkg::COEF_W'(h01_reg);
        e11          = hts_pkg::COEF_W'(rd_data);
        one_minus_bz = {1'b1, {FW{1'b0}}} - {1'b0, bz_reg};
        if (!vz_reg[0])
        begin
            sel_c = e00;
            if (bz_reg > bx_reg)
            begin
                sel_a = e11 - e01;
                sel_b = e01 - e00;
            end
            else
            begin
                sel_a = e10 - e00;
                sel_b = e11 - e10;
            end
        end
        else if (one_minus_bz > {1'b0, bx_reg})
        begin
            sel_c = e00;
            sel_a = e10 - e00;
            sel_b = e01 - e00;
        end
        else
        begin
            sel_c = e10 + e01 - e11;
            sel_a = e11 - e01;
            sel_b = e11 - e10;
        end
    end

    // Divide by 255 as a shift-add series, short by at most one, then fixed.
    logic [hts_pkg::SCALE_W-1:0] rnd_sum;
    logic [hts_pkg::SER_W-1:0]   series;
    logic [hts_pkg::TQ_W-1:0]    q_times;
    logic [hts_pkg::TQ_W-1:0]    rem;
    logic [hts_pkg::SUM_W-1:0]   res_sum;
    logic [hts_pkg::DATA_W-1:0]  res_sat;

    always_comb
    begin
        rnd_sum = prod[hts_pkg::SCALE_W-1:0] + hts_pkg::SCALE_W'(hts_pkg::ROUND_BIAS);
        series  = hts_pkg::SER_W'(t_reg) + hts_pkg::SER_W'(t_reg >> 8)
                + hts_pkg::SER_W'(t_reg >> 16) + hts_pkg::SER_W'(t_reg >> 24)
                + hts_pkg::SER_W'(t_reg >> 32) + hts_pkg::SER_W'(t_reg >> 40);
        q_times = (hts_pkg::TQ_W'(qest_reg) << 8) - hts_pkg::TQ_W'(qest_reg);
        rem     = t_reg - q_times;
        res_sum = {{(hts_pkg::SUM_W - hts_pkg::DATA_W){origin_y_reg[hts_pkg::DATA_W-1]}},
                   origin_y_reg}
                + hts_pkg::SUM_W'(q_reg);
        // The quotient is never negative, so only the upper bound can be crossed.
        if (!res_sum[hts_pkg::SUM_W-1] && (|res_sum[hts_pkg::SUM_W-2:hts_pkg::DATA_W-1]))
        begin
            res_sat = {1'b0, {(hts_pkg::DATA_W - 1){1'b1}}};
        end
        else
        begin
            res_sat = res_sum[hts_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.state)
            hts_pkg::ST_IDLE:
            begin
                mag_x_reg    <= diff_x[hts_pkg::DATA_W] ? ndiff_x[hts_pkg::DATA_W-1:0]
                                                        : diff_x[hts_pkg::DATA_W-1:0];
                mag_z_reg    <= diff_z[hts_pkg::DATA_W] ? ndiff_z[hts_pkg::DATA_W-1:0]
                                                        : diff_z[hts_pkg::DATA_W-1:0];
                dneg_x_reg   <= diff_x[hts_pkg::DATA_W];
                dneg_z_reg   <= diff_z[hts_pkg::DATA_W];
                clamp_reg    <= clamp_enable;
                hit_flag_reg <= 1'b0;
            end
            hts_pkg::ST_MUL_Z:
            begin
                lx_reg <= g_lx;
                nx_reg <= g_below;
            end
            hts_pkg::ST_GRID_Z:
            begin
                lz_reg <= g_lx;
                nz_reg <= g_below;
            end
            hts_pkg::ST_CHECK:
            begin
                vx_reg       <= sel_x[FW +: IDX_W];
                bx_reg       <= sel_x[FW-1:0];
                vz_reg       <= sel_z[FW +: IDX_W];
                bz_reg       <= sel_z[FW-1:0];
                hit_flag_reg <= !miss;
            end
            hts_pkg::ST_RD0:
            begin
                base_reg <= base_now;
            end
            hts_pkg::ST_RD1:
            begin
                h00_reg <= rd_data;
            end
            hts_pkg::ST_RD2:
            begin
                h10_reg <= rd_data;
            end
            hts_pkg::ST_RD3:
            begin
                h01_reg <= rd_data;
            end
            hts_pkg::ST_SEL:
            begin
                coef_a_reg <= sel_a;
                coef_b_reg <= sel_b;
                acc_reg    <= {{(hts_pkg::ACC_W - hts_pkg::COEF_W - FW){sel_c[hts_pkg::COEF_W-1]}},
                               sel_c, {FW{1'b0}}};
            end
            hts_pkg::ST_MUL_B, hts_pkg::ST_ACC:
            begin
                acc_reg <= acc_reg + prod[hts_pkg::ACC_W-1:0];
            end
            hts_pkg::ST_DIV0:
            begin
                t_reg <= rnd_sum[hts_pkg::SCALE_W-1:FW];
            end
            hts_pkg::ST_DIV1:
            begin
                qest_reg <= hts_pkg::QUO_W'(series >> 8);
            end
            hts_pkg::ST_DIV2:
            begin
                q_reg <= qest_reg + hts_pkg::QUO_W'(rem >= hts_pkg::TQ_W'(hts_pkg::DIV_CONST));
            end
            default:
            begin
            end
        endcase
    end

    // Output register.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            hit_reg    <= hit_flag_reg;
            height_reg <= hit_flag_reg ? res_sat : '0;
        end
    end

    hts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .cmd        (cmd),
        .clear_busy (clear_busy),
        .miss       (miss),
        .out_free   (out_free),
        .ctl        (ctl)
    );

    assign in_ready   = ctl.ready;
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign height_out = height_reg;

    `HTS_ASSERT_SAME(a_no_request_in_clear, clear_busy, !in_ready, "request taken while clearing")
    `HTS_ASSERT_SAME(a_result_from_fin, $rose(out_valid_reg), $past(ctl.state == hts_pkg::ST_FIN), "result without final step")
    `HTS_ASSERT_SAME(a_miss_is_zero, out_valid_reg && !hit_reg, height_reg == '0, "miss with nonzero height")
    `HTS_ASSERT_NEXT(a_write_to_fin, ctl.accept && (cmd == hts_pkg::CMD_WRITE), ctl.state == hts_pkg::ST_FIN, "write did not go to final step")

endmodule

`default_nettype wire
